FILE: sv/spq_pkg.sv
`default_nettype none

package spq_pkg;

	localparam int HANDLE_W  = 16;
	localparam int KEY_W     = 32;
	localparam int PRIO_W    = 8;
	localparam int DEPTH_DEF = 16;
	localparam int CNT_OUT_W = 5;

	localparam logic FUNC_PUSH = 1'b0;
	localparam logic FUNC_POP  = 1'b1;

	localparam logic MODE_TIME = 1'b0;
	localparam logic MODE_PRIO = 1'b1;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		logic [HANDLE_W-1:0] handle;
		logic [KEY_W-1:0]    key;
	} entry_t;

	// broadcast to every cell
	typedef struct packed {
		logic                push;
		logic                pop;
		logic                mode;
		logic [KEY_W-1:0]    key;
		logic [HANDLE_W-1:0] handle;
	} op_t;

	typedef struct packed {
		logic [CNT_OUT_W-1:0] queue_count;
		status_t              status;
		logic                 out_valid;
		logic [HANDLE_W-1:0]  out_handle;
	} result_t;

endpackage

`default_nettype wire

FILE: sv/spq_cell.sv
`default_nettype none

module spq_cell (
	input  wire              clk,
	input  wire spq_pkg::op_t    op,
	input  wire              occ,
	input  wire              run_in,
	input  wire              shift_in,
	input  wire spq_pkg::entry_t prev_ent,
	input  wire spq_pkg::entry_t next_ent,
	output logic             run_out,
	output spq_pkg::entry_t  ent
);
	import spq_pkg::*;

	entry_t ent_q;
	logic   beats;
	logic   take_new;

	assign beats    = (op.mode == MODE_PRIO) ? (op.key > ent_q.key) : (op.key < ent_q.key);
	// run_out: this cell and every cell behind it are passed by the new key
	assign run_out  = run_in && (!occ || beats);
	assign take_new = run_out && !shift_in;
	assign ent      = ent_q;

	always_ff @(posedge clk) begin
		if (op.push) begin
			if (take_new) begin
				ent_q.handle <= op.handle;
				ent_q.key    <= op.key;
			end else if (run_out) begin
				ent_q <= prev_ent;
			end
		end else if (op.pop) begin
			ent_q <= next_ent;
		end
	end

endmodule

`default_nettype wire

FILE: sv/sorted_priority_queue.sv
// Sorted priority queue of request handles, built as a row of cells.
// s_* channel: one item per handshake. s_tuser is the operation (0 push,
//   1 pop). s_tdata = {priority[55:48], time[47:16], handle[15:0]}.
// m_* channel: exactly one result item per input item.
//   m_tdata = {queue_count[23:19], status[18:17], out_valid[16], handle[15:0]}.
// cfg_* channel: order_mode, bit 0 (0 smallest time first, 1 largest
//   priority first). Always ready; write only while the queue is idle.
// Every cell compares the incoming key against its own entry in the same
// cycle, so a push or pop completes at the handshake: the result appears on
// m_* in the cycle after the input handshake, and one item per cycle is taken
// as long as the receiver keeps up. The result register holds one item;
// while the receiver stalls it, s_tready drops and the queue is frozen.
// Reset clears the entry count, the mode and the output register; entry
// storage is not cleared, since only entries below the count are read.
// A push on a full queue or a pop on an empty queue changes nothing and
// is reported through status.
`default_nettype none

module sorted_priority_queue #(
	parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [55:0] s_tdata,   // handle[15:0], time[47:16], priority[55:48]
	input  wire         s_tuser,   // func
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [23:0] m_tdata,   // out_handle[15:0], out_valid[16], status[18:17],
	                               // queue_count[23:19]
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [0:0]  cfg_data
);
	import spq_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);

	logic          mode_q;
	logic [CW-1:0] count_q;
	logic          m_valid_q;
	result_t       res_q;

	logic          acc, full, empty, push_ok, pop_ok;
	logic [KEY_W-1:0] in_key;
	op_t           op;
	entry_t        ent [DEPTH];
	logic          run [DEPTH+1];
	logic [CW+CNT_OUT_W-1:0] cnt_ext;
	logic [CW-1:0] count_d;
	result_t       res_d;

	assign cfg_ready = 1'b1;
	assign s_tready  = !m_valid_q || m_tready;
	assign acc       = s_tvalid && s_tready;
	assign full      = (count_q == CW'(DEPTH));
	assign empty     = (count_q == '0);
	assign push_ok   = acc && (s_tuser == FUNC_PUSH) && !full;
	assign pop_ok    = acc && (s_tuser == FUNC_POP) && !empty;

	assign in_key = (mode_q == MODE_PRIO) ? {{(KEY_W-PRIO_W){1'b0}}, s_tdata[55:48]}
	                                      : s_tdata[47:16];

	assign op.push   = push_ok;
	assign op.pop    = pop_ok;
	assign op.mode   = mode_q;
	assign op.key    = in_key;
	assign op.handle = s_tdata[15:0];

	assign run[DEPTH] = 1'b1;

	genvar i;
	generate
		for (i = 0; i < DEPTH; i++) begin : g_cell
			spq_cell u_cell (
				.clk      (clk),
				.op       (op),
				.occ      (count_q > CW'(i)),
				.run_in   (run[i+1]),
				.shift_in ((i == 0) ? 1'b0 : run[(i == 0) ? 0 : i-1]),
				.prev_ent (ent[(i == 0) ? 0 : i-1]),
				.next_ent (ent[(i == DEPTH-1) ? DEPTH-1 : i+1]),
				.run_out  (run[i]),
				.ent      (ent[i])
			);
		end
	endgenerate

	always_comb begin
		count_d = count_q;
		if (push_ok)
			count_d = count_q + 1'b1;
		else if (pop_ok)
			count_d = count_q - 1'b1;
	end

	assign cnt_ext = {{CNT_OUT_W{1'b0}}, count_d};

	always_comb begin
		res_d.out_handle  = pop_ok ? ent[0].handle : '0;
		res_d.out_valid   = pop_ok;
		res_d.queue_count = cnt_ext[CNT_OUT_W-1:0];
		if (s_tuser == FUNC_PUSH && full)
			res_d.status = ST_FULL;
		else if (s_tuser == FUNC_POP && empty)
			res_d.status = ST_EMPTY;
		else
			res_d.status = ST_OK;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_TIME;
			count_q   <= '0;
			m_valid_q <= 1'b0;
			res_q     <= '0;
		end else begin
			if (cfg_valid && cfg_ready)
				mode_q <= cfg_data[0];
			count_q <= count_d;
			if (acc) begin
				m_valid_q <= 1'b1;
				res_q     <= res_d;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = res_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count above depth");

	a_full_hold: assert property (@(posedge clk) disable iff (!arst_n)
		acc && s_tuser == FUNC_PUSH && full |=> $stable(count_q))
		else $error("refused push changed count");

	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		acc && s_tuser == FUNC_POP && !empty |=> res_q.out_valid && res_q.status == ST_OK)
		else $error("pop result not flagged valid");

	a_empty_status: assert property (@(posedge clk) disable iff (!arst_n)
		acc && s_tuser == FUNC_POP && empty |=> !res_q.out_valid && res_q.status == ST_EMPTY)
		else $error("empty pop not reported");

	a_result_out: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> m_tvalid)
		else $error("accepted item produced no result");

endmodule

`default_nettype wire
